/* rtl/osm_pkg.sv */
// Shared constants, types and control structs for the order-statistic multiset.
`timescale 1ns / 1ps
`default_nettype none
package osm_pkg;

  // Store geometry.
  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port widths fixed by the interface.
  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int RANK_W    = 8;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic upd;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/osm_ctrl.sv */
// Controller state machine: sequences the update and rank-read cycles.
`timescale 1ns / 1ps
`default_nettype none
module osm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output osm_pkg::cmd_t      cmd
);

  osm_pkg::state_t state;
  osm_pkg::state_t state_next;
  logic            out_valid_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      osm_pkg::ST_IDLE: begin
        if (in_valid) state_next = osm_pkg::ST_READ;
      end
      osm_pkg::ST_READ: begin
        if (!out_valid || out_ready) state_next = osm_pkg::ST_IDLE;
      end
      default: state_next = osm_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands. No word is taken while reset is held.
  always_comb begin
    in_ready     = 1'b0;
    cmd.upd      = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      osm_pkg::ST_IDLE: begin
        in_ready = !rst;
        cmd.upd  = in_valid && !rst;
      end
      osm_pkg::ST_READ: begin
        cmd.load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The output word stays valid until it is taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/osm_datapath.sv */
// Datapath: row of compare-and-shift cells, key count and output register.
`timescale 1ns / 1ps
`default_nettype none
module osm_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire osm_pkg::cmd_t                   cmd,
  input  wire logic                            req_type,
  input  wire logic [osm_pkg::IN_KEY_W-1:0]    key,
  input  wire logic [osm_pkg::RANK_W-1:0]      rank,
  output logic      [osm_pkg::OUT_KEY_W-1:0]   kth_key,
  output logic                                 found,
  output logic                                 insert_dropped,
  output logic                                 delete_missed
);

  osm_pkg::key_t cells [osm_pkg::CAPACITY];
  osm_pkg::key_t cells_next [osm_pkg::CAPACITY];
  osm_pkg::cnt_t count;
  osm_pkg::cnt_t count_next;

  osm_pkg::key_t           k_in;
  logic [osm_pkg::CAPACITY-1:0] gt;
  logic [osm_pkg::CAPACITY-1:0] ge;
  logic [osm_pkg::CAPACITY-1:0] eq;
  logic                    full;
  logic                    hit;
  logic                    dropped_now;
  logic                    missed_now;

  logic [osm_pkg::RANK_W-1:0] rank_q;
  logic                       dropped_q;
  logic                       missed_q;

  logic [31:0]     rank_ext;
  logic            rank_ok;
  osm_pkg::idx_t   rd_idx;
  logic [63:0]     rd_wide;

  assign k_in = osm_pkg::key_t'(key);
  assign full = (count == osm_pkg::CNT_W'(osm_pkg::CAPACITY));

  // Per-cell comparisons against the incoming key, valid entries only.
  always_comb begin
    for (int i = 0; i < osm_pkg::CAPACITY; i++) begin
      gt[i] = (osm_pkg::CNT_W'(i) < count) && (cells[i] >  k_in);
      ge[i] = (osm_pkg::CNT_W'(i) < count) && (cells[i] >= k_in);
      eq[i] = (osm_pkg::CNT_W'(i) < count) && (cells[i] == k_in);
    end
  end

  assign hit         = |eq;
  assign dropped_now = (req_type == osm_pkg::REQ_INSERT) && full;
  assign missed_now  = (req_type == osm_pkg::REQ_DELETE) && !hit;

  // Next cell contents: larger keys move up on insert, down on delete.
  always_comb begin
    for (int i = 0; i < osm_pkg::CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (req_type == osm_pkg::REQ_INSERT) begin
        if (!full) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cells_next[i] = cells[(i > 0) ? i - 1 : 0];
          end else if (gt[i] || (osm_pkg::CNT_W'(i) == count)) begin
            cells_next[i] = k_in;
          end
        end
      end else begin
        if (hit && ge[i] && (i < osm_pkg::CAPACITY - 1)) begin
          cells_next[i] = cells[(i < osm_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Count update.
  always_comb begin
    count_next = count;
    if (req_type == osm_pkg::REQ_INSERT) begin
      if (!full) count_next = count + osm_pkg::CNT_W'(1);
    end else begin
      if (hit) count_next = count - osm_pkg::CNT_W'(1);
    end
  end

  // Cell row and captured request fields.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      for (int i = 0; i < osm_pkg::CAPACITY; i++) begin
        cells[i] <= cells_next[i];
      end
      rank_q    <= rank;
      dropped_q <= dropped_now;
      missed_q  <= missed_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.upd) begin
      count <= count_next;
    end
  end

  // Rank selection on the updated store.
  assign rank_ext = 32'(rank_q);
  assign rank_ok  = rank_ext < 32'(count);
  assign rd_idx   = rank_ext[osm_pkg::IDX_W-1:0];
  assign rd_wide  = 64'(cells[rd_idx]);

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kth_key        <= rank_ok ? rd_wide[osm_pkg::OUT_KEY_W-1:0] : '0;
      found          <= rank_ok;
      insert_dropped <= dropped_q;
      delete_missed  <= missed_q;
    end
  end

endmodule
`default_nettype wire

/* rtl/order_statistic_multiset.sv */
// Top level of the order-statistic multiset: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each input word inserts one copy of a key into a sorted multiset of up to
// 256 keys, or deletes one copy, and the output word then gives the key at the
// requested zero-based rank (found=0, kth_key=0 when the rank is at or beyond
// the count). A full-store insert is dropped and flagged; deleting an absent
// key is flagged. An item first updates every cell of the compare-and-shift
// row in parallel, then goes through the registered rank select, which waits
// while an unread word is held. The output register holds a finished word
// while the next input word is accepted. No clearing pass is needed after
// reset: the key count alone marks which cells hold data.
module order_statistic_multiset (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            req_type,
  input  wire logic [osm_pkg::IN_KEY_W-1:0]    key,
  input  wire logic [osm_pkg::RANK_W-1:0]      rank,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [osm_pkg::OUT_KEY_W-1:0]   kth_key,
  output logic                                 found,
  output logic                                 insert_dropped,
  output logic                                 delete_missed
);

  osm_pkg::cmd_t cmd;

  // Control sequencing.
  osm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Store and result path.
  osm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .key            (key),
    .rank           (rank),
    .kth_key        (kth_key),
    .found          (found),
    .insert_dropped (insert_dropped),
    .delete_missed  (delete_missed)
  );

endmodule
`default_nettype wire
